// ===== rtl/lgd_pkg.sv =====
// Shared types and constants of the life grid draw and step unit.
`default_nettype none

package lgd_pkg;

	// Operation selector carried on the input tuser lane.
	typedef enum logic [1:0] {
		OP_PEN  = 2'd0,
		OP_STEP = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// Pen command bytes (ASCII w, s, a, d, x).
	localparam logic [7:0] CMD_UP     = 8'h77;
	localparam logic [7:0] CMD_DOWN   = 8'h73;
	localparam logic [7:0] CMD_LEFT   = 8'h61;
	localparam logic [7:0] CMD_RIGHT  = 8'h64;
	localparam logic [7:0] CMD_TOGGLE = 8'h78;

	// Cursor saturation bounds.
	localparam logic signed [15:0] CURSOR_MIN = 16'sh8000;
	localparam logic signed [15:0] CURSOR_MAX = 16'sh7fff;

	// Neighbor counts of the life rule.
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PEN_RD,
		ST_PEN_WR,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_STEP_L0,
		ST_STEP_L1,
		ST_STEP_L2,
		ST_STEP_COL,
		ST_STEP_WB,
		ST_STEP_ZERO,
		ST_DONE
	} state_t;

	// Control from the sequencer to the generation unit.
	typedef struct packed {
		logic clear;
		logic shift_in;
		logic row_keep;
		logic rotate;
		logic first_col;
		logic last_col;
		logic col_live;
	} life_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/life_grid_draw_and_step_unit.sv =====
// Top level of the life grid draw and step unit: sequencer, pen and output register.
//
// Input words arrive on s_tvalid/s_tready with the operation in s_tuser and the
// pen command and read position in s_tdata. Each word yields exactly one output
// word on m_tvalid/m_tready: the read cell, the cursor and the pen state.
// Grid size is set through cfg_we/cfg_index/cfg_data, by the user only while the
// block is idle; the block does not enforce it. One item is worked at a time;
// s_tready is high only in the idle state. States between acceptance and ST_DONE:
//   pen command with the pen up or an ignored byte: none, with the pen down:
//   ST_PEN_RD, then ST_PEN_WR when the cursor is on the grid (read-modify-write of
//   a row), cell read: ST_RD_ISSUE, ST_RD_DATA, unused op: none, generation step:
//   ST_STEP_L0 to L2, ST_STEP_COL and ST_STEP_WB per row in use, ST_STEP_ZERO per
//   row beyond; the cell rule unit visits every column of each live row once.
// The cells are held as MAX_HEIGHT rows of MAX_WIDTH bits in one memory with one
// read and one write port; its port sets the row-at-a-time schedule.
// After reset the memory is cleared one row per cycle, all MAX_HEIGHT rows, before
// the first word is taken; configuration writes are taken throughout.
// A finished result waits in the output register while the next word is taken;
// if the receiver stalls, the following result waits until that register frees.
`default_nettype none

module life_grid_draw_and_step_unit import lgd_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input word.
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,  // command[7:0], read_col[13:8], read_row[19:14], zero[23:20]
	input  wire  [1:0]  s_tuser,  // op[1:0]
	// Output word.
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // cell_alive[0], cursor_col[16:1], cursor_row[32:17],
	                              // pen_is_down[33], zero[39:34]
	// Configuration write port.
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [6:0]  cfg_data
);

	localparam int RAW = $clog2(MAX_HEIGHT);
	localparam int CAW = $clog2(MAX_WIDTH);
	localparam logic [6:0] W_MAX7 = 7'((MAX_WIDTH > 127) ? 127 : MAX_WIDTH);
	localparam logic [6:0] H_MAX7 = 7'((MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT);
	localparam logic [6:0] W_RST  = 7'((MAX_WIDTH > 64) ? 64 : MAX_WIDTH);
	localparam logic [6:0] H_RST  = 7'((MAX_HEIGHT > 64) ? 64 : MAX_HEIGHT);

	state_t                 state_q, state_d;
	logic [RAW:0]           row_q;
	logic [CAW-1:0]         col_q;
	logic signed [15:0]     pen_col_q, pen_row_q;
	logic                   pen_down_q;
	logic [6:0]             eff_w_q, eff_h_q;
	logic [5:0]             rd_col_q, rd_row_q;
	logic                   alive_q;
	logic                   out_valid_q;
	logic [39:0]            out_data_q;

	// Input fields.
	op_t                    in_op;
	logic [7:0]             in_cmd;
	logic                   accept;
	logic                   cmd_known;
	logic                   pen_down_after;

	// Sequencer outputs.
	logic                   row_clr, row_inc, col_clr, col_inc, out_load;
	logic                   mem_rd_en, mem_wr_en;
	logic [RAW-1:0]         mem_rd_addr, mem_wr_addr;
	logic [MAX_WIDTH-1:0]   mem_wr_data, mem_rd_data;
	logic [MAX_WIDTH-1:0]   new_row;
	life_ctrl_t             ctrl;

	// Derived positions and checks.
	logic [RAW:0]           row_p1, row_p2;
	logic                   keep_p1, keep_p2, row1_live, row_last;
	logic [CAW-1:0]         rd_col_idx, pen_col_idx;
	logic [RAW-1:0]         rd_row_idx;
	logic                   rd_in_grid, pen_in_grid, rd_hit;
	logic [6:0]             w_clamp, h_clamp;

	assign in_op  = op_t'(s_tuser);
	assign in_cmd = s_tdata[7:0];
	assign accept = s_tvalid & s_tready;
	assign s_tready = (state_q == ST_IDLE);

	assign cmd_known = (in_cmd == CMD_UP) | (in_cmd == CMD_DOWN) | (in_cmd == CMD_LEFT)
		| (in_cmd == CMD_RIGHT) | (in_cmd == CMD_TOGGLE);
	assign pen_down_after = (in_cmd == CMD_TOGGLE) ? ~pen_down_q : pen_down_q;

	// Row positions used by the step sweep.
	assign row_p1    = row_q + (RAW+1)'(1);
	assign row_p2    = row_q + (RAW+1)'(2);
	assign keep_p1   = (32'(row_p1) < 32'(eff_h_q));
	assign keep_p2   = (32'(row_p2) < 32'(eff_h_q));
	assign row1_live = (32'd1 < 32'(eff_h_q));
	assign row_last  = (32'(row_q) == 32'(MAX_HEIGHT - 1));

	// Cell read position.
	assign rd_col_idx = CAW'(rd_col_q);
	assign rd_row_idx = RAW'(rd_row_q);
	assign rd_in_grid = (7'(rd_col_q) < eff_w_q) & (7'(rd_row_q) < eff_h_q);
	assign rd_hit     = rd_in_grid & mem_rd_data[rd_col_idx];

	// The cursor marks only inside the grid in use.
	assign pen_col_idx = pen_col_q[CAW-1:0];
	assign pen_in_grid = ~pen_col_q[15] & ~pen_row_q[15]
		& (pen_col_q < $signed({9'd0, eff_w_q}))
		& (pen_row_q < $signed({9'd0, eff_h_q}));

	// Register values outside 1..maximum are clamped on write.
	assign w_clamp = (cfg_data == 7'd0) ? 7'd1
		: ((32'(cfg_data) > MAX_WIDTH) ? W_MAX7 : cfg_data);
	assign h_clamp = (cfg_data == 7'd0) ? 7'd1
		: ((32'(cfg_data) > MAX_HEIGHT) ? H_MAX7 : cfg_data);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory port and generation unit control.
	always_comb begin
		state_d     = state_q;
		row_clr     = 1'b0;
		row_inc     = 1'b0;
		col_clr     = 1'b0;
		col_inc     = 1'b0;
		out_load    = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = row_q[RAW-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = row_q[RAW-1:0];
		mem_wr_data = '0;
		ctrl        = '0;
		ctrl.first_col = (col_q == '0);
		ctrl.last_col  = (32'(col_q) == 32'(MAX_WIDTH - 1));
		ctrl.col_live  = (32'(col_q) < 32'(eff_w_q));
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
				row_inc   = 1'b1;
				if (row_last) begin
					row_clr = 1'b1;
					row_inc = 1'b0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_PEN:  state_d = (cmd_known && pen_down_after) ? ST_PEN_RD : ST_DONE;
						OP_STEP: begin
							row_clr = 1'b1;
							col_clr = 1'b1;
							state_d = ST_STEP_L0;
						end
						OP_READ: state_d = ST_RD_ISSUE;
						OP_NONE: state_d = ST_DONE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PEN_RD: begin
				mem_rd_en   = pen_in_grid;
				mem_rd_addr = pen_row_q[RAW-1:0];
				state_d     = pen_in_grid ? ST_PEN_WR : ST_DONE;
			end
			ST_PEN_WR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = pen_row_q[RAW-1:0];
				mem_wr_data = mem_rd_data | (MAX_WIDTH'(1) << pen_col_idx);
				state_d     = ST_DONE;
			end
			ST_RD_ISSUE: begin
				mem_rd_en   = rd_in_grid;
				mem_rd_addr = rd_row_idx;
				state_d     = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				state_d = ST_DONE;
			end
			ST_STEP_L0: begin
				// Empty window, fetch row zero.
				ctrl.clear  = 1'b1;
				mem_rd_en   = 1'b1;
				mem_rd_addr = '0;
				state_d     = ST_STEP_L1;
			end
			ST_STEP_L1: begin
				ctrl.shift_in = 1'b1;
				ctrl.row_keep = 1'b1;
				mem_rd_en     = row1_live;
				mem_rd_addr   = RAW'(1);
				state_d       = ST_STEP_L2;
			end
			ST_STEP_L2: begin
				ctrl.shift_in = 1'b1;
				ctrl.row_keep = row1_live;
				state_d       = ST_STEP_COL;
			end
			ST_STEP_COL: begin
				// Fetch the row two below while this row is swept.
				ctrl.rotate = 1'b1;
				mem_rd_en   = ctrl.first_col & keep_p2;
				mem_rd_addr = row_p2[RAW-1:0];
				col_inc     = 1'b1;
				if (ctrl.last_col) begin
					col_clr = 1'b1;
					col_inc = 1'b0;
					state_d = ST_STEP_WB;
				end
			end
			ST_STEP_WB: begin
				mem_wr_en     = 1'b1;
				mem_wr_data   = new_row;
				ctrl.shift_in = 1'b1;
				ctrl.row_keep = keep_p2;
				row_inc       = 1'b1;
				if (keep_p1) begin
					state_d = ST_STEP_COL;
				end else if (row_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_STEP_ZERO;
				end
			end
			ST_STEP_ZERO: begin
				// Rows beyond the grid in use are cleared by a step.
				mem_wr_en = 1'b1;
				row_inc   = 1'b1;
				if (row_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Row and column counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else begin
			if (row_clr) begin
				row_q <= '0;
			end else if (row_inc) begin
				row_q <= row_p1;
			end
			if (col_clr) begin
				col_q <= '0;
			end else if (col_inc) begin
				col_q <= col_q + CAW'(1);
			end
		end
	end

	// Pen cursor and pen state, updated when a pen command is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_col_q  <= '0;
			pen_row_q  <= '0;
			pen_down_q <= 1'b0;
		end else if (accept && in_op == OP_PEN) begin
			priority if (in_cmd == CMD_UP) begin
				if (pen_row_q != CURSOR_MIN) pen_row_q <= pen_row_q - 16'sd1;
			end else if (in_cmd == CMD_DOWN) begin
				if (pen_row_q != CURSOR_MAX) pen_row_q <= pen_row_q + 16'sd1;
			end else if (in_cmd == CMD_LEFT) begin
				if (pen_col_q != CURSOR_MIN) pen_col_q <= pen_col_q - 16'sd1;
			end else if (in_cmd == CMD_RIGHT) begin
				if (pen_col_q != CURSOR_MAX) pen_col_q <= pen_col_q + 16'sd1;
			end else if (in_cmd == CMD_TOGGLE) begin
				pen_down_q <= ~pen_down_q;
			end else begin
				pen_down_q <= pen_down_q;
			end
		end
	end

	// Grid size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= W_RST;
			eff_h_q <= H_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  eff_w_q <= w_clamp;
				REG_GRID_HEIGHT: eff_h_q <= h_clamp;
				default:         eff_w_q <= eff_w_q;
			endcase
		end
	end

	// Read position and cell result.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_col_q <= s_tdata[13:8];
			rd_row_q <= s_tdata[19:14];
			alive_q  <= 1'b0;
		end else if (state_q == ST_RD_DATA) begin
			alive_q  <= rd_hit;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, pen_down_q, pen_row_q, pen_col_q, alive_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Cell memory, one row per entry.
	lgd_grid_mem #(
		.DEPTH (MAX_HEIGHT),
		.WIDTH (MAX_WIDTH)
	) u_grid_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Shared cell rule unit.
	lgd_life_unit #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_life_unit (
		.clk      (clk),
		.ctrl     (ctrl),
		.eff_w    (eff_w_q),
		.row_data (mem_rd_data),
		.new_row  (new_row)
	);

endmodule

`default_nettype wire

// ===== rtl/lgd_grid_mem.sv =====
// Row-organized cell memory: one write port and one registered read port.
`default_nettype none

module lgd_grid_mem import lgd_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire                     rd_en,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lgd_life_unit.sv =====
// Generation unit: three-row window, one cell rule evaluated per cycle while ctrl.rotate is set.
`default_nettype none

module lgd_life_unit import lgd_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  wire                  clk,
	input  wire life_ctrl_t      ctrl,
	input  wire [6:0]            eff_w,
	input  wire [MAX_WIDTH-1:0]  row_data,
	output logic [MAX_WIDTH-1:0] new_row
);

	logic [MAX_WIDTH-1:0] up_q;
	logic [MAX_WIDTH-1:0] mid_q;
	logic [MAX_WIDTH-1:0] dn_q;
	logic [MAX_WIDTH-1:0] new_q;
	logic [MAX_WIDTH-1:0] col_mask;
	logic                 left_up, left_mid, left_dn;
	logic                 right_up, right_mid, right_dn;
	logic [3:0]           count;
	logic                 cell_next;

	// Columns beyond the grid in use read as dead.
	for (genvar gi = 0; gi < MAX_WIDTH; gi++) begin : g_mask
		assign col_mask[gi] = (32'(gi) < 32'(eff_w));
	end

	// The rows rotate right each column: bit 0 is the current column, bit 1 the
	// one to its right and the top bit the one to its left. Edges are dead.
	assign left_up   = up_q[MAX_WIDTH-1]  & ~ctrl.first_col;
	assign left_mid  = mid_q[MAX_WIDTH-1] & ~ctrl.first_col;
	assign left_dn   = dn_q[MAX_WIDTH-1]  & ~ctrl.first_col;
	assign right_up  = up_q[1]  & ~ctrl.last_col;
	assign right_mid = mid_q[1] & ~ctrl.last_col;
	assign right_dn  = dn_q[1]  & ~ctrl.last_col;

	// Neighbor count and the birth and survival rule.
	assign count = 4'(left_up) + 4'(up_q[0]) + 4'(right_up)
		+ 4'(left_mid) + 4'(right_mid)
		+ 4'(left_dn) + 4'(dn_q[0]) + 4'(right_dn);
	assign cell_next = ctrl.col_live
		& ((count == BIRTH_COUNT) | (mid_q[0] & (count == SURVIVE_COUNT)));

	// Window and result row registers.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			up_q  <= '0;
			mid_q <= '0;
			dn_q  <= '0;
		end else if (ctrl.shift_in) begin
			up_q  <= mid_q;
			mid_q <= dn_q;
			dn_q  <= ctrl.row_keep ? (row_data & col_mask) : '0;
		end else if (ctrl.rotate) begin
			up_q  <= {up_q[0], up_q[MAX_WIDTH-1:1]};
			mid_q <= {mid_q[0], mid_q[MAX_WIDTH-1:1]};
			dn_q  <= {dn_q[0], dn_q[MAX_WIDTH-1:1]};
			new_q <= {cell_next, new_q[MAX_WIDTH-1:1]};
		end
	end

	assign new_row = new_q;

endmodule

`default_nettype wire
